>>> hw/rtl/ipv4tpc_pkg.sv
// ----------------------------------------------------------------------------
// ipv4tpc_pkg
// Shared constants for the dotted-quad text parser: character codes, octet
// limits and the reserved address blocks as prefix/mask pairs.
// ----------------------------------------------------------------------------
package ipv4tpc_pkg;

  // character codes
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;
  localparam logic [7:0] CHAR_DOT  = 8'd46;

  // octet limits
  localparam int          OCTET_W     = 8;
  localparam int          COUNT_W     = 3;
  localparam logic [2:0]  OCTETS_FULL = 3'd4;
  localparam logic [11:0] OCTET_MAX   = 12'd255;
  localparam logic [3:0]  DEC_RADIX   = 4'd10;

  // reserved blocks, each an aligned prefix
  localparam int N_RANGES = 14;

  typedef logic [31:0] ipv4_addr_t;

  localparam ipv4_addr_t RANGE_BASE [N_RANGES] = '{
    32'h0000_0000,  // 0.0.0.0/8
    32'h0A00_0000,  // 10.0.0.0/8
    32'h7F00_0000,  // 127.0.0.0/8
    32'hA9FE_0000,  // 169.254.0.0/16
    32'hAC10_0000,  // 172.16.0.0/12
    32'hC000_0000,  // 192.0.0.0/24
    32'hC000_0200,  // 192.0.2.0/24
    32'hC058_6300,  // 192.88.99.0/24
    32'hC0A8_0000,  // 192.168.0.0/16
    32'hC612_0000,  // 198.18.0.0/15
    32'hC633_6400,  // 198.51.100.0/24
    32'hCB00_7100,  // 203.0.113.0/24
    32'hE000_0000,  // 224.0.0.0/4
    32'hF000_0000   // 240.0.0.0/4
  };

  localparam ipv4_addr_t RANGE_MASK [N_RANGES] = '{
    32'hFF00_0000,
    32'hFF00_0000,
    32'hFF00_0000,
    32'hFFFF_0000,
    32'hFFF0_0000,
    32'hFFFF_FF00,
    32'hFFFF_FF00,
    32'hFFFF_FF00,
    32'hFFFF_0000,
    32'hFFFE_0000,
    32'hFFFF_FF00,
    32'hFFFF_FF00,
    32'hF000_0000,
    32'hF000_0000
  };

  // true when the address falls in any reserved block
  function automatic logic is_reserved(input ipv4_addr_t addr);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < N_RANGES; i++) begin
      if ((addr & RANGE_MASK[i]) == RANGE_BASE[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

>>> hw/rtl/ipv4_text_parse_classify_top.sv
// ----------------------------------------------------------------------------
// ipv4_text_parse_classify_top
// Streaming dotted-quad IPv4 text parser with reserved-block classification.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) carries one ASCII character per
//   transaction, in_final_char marking the last character of a text. Every
//   character updates the parse state in the cycle it is taken; only the
//   final character produces a transaction on the output channel
//   (out_valid/out_ready) with out_addr_valid, out_address and out_reserved.
//   The result is registered and appears in the cycle after the final
//   character is taken. Throughput: one character per cycle unless a result
//   stalls; octet update (multiply by ten, add, compare) is combinational.
//   While a result waits and out_ready is low, in_ready is low; the result
//   register holds its value until taken. A result taken in the same cycle
//   frees the register for the next character.
//   Reset (rst_n low, synchronous) clears the parse state and empties the
//   result register; no clearing pass is needed.
//   Invalid texts report zero address and zero reserved flag, and the parse
//   state is cleared after every final character.
// ----------------------------------------------------------------------------
module ipv4_text_parse_classify_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_char_code,
  input  logic                      in_final_char,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_addr_valid,
  output ipv4tpc_pkg::ipv4_addr_t   out_address,
  output logic                      out_reserved
);
  import ipv4tpc_pkg::*;

  // parse state
  logic [OCTET_W-1:0]   octet_value_r,    octet_value_nxt;
  logic [COUNT_W-1:0]   octet_count_r,    octet_count_nxt;
  logic                 digit_seen_r,     digit_seen_nxt;
  logic [3*OCTET_W-1:0] earlier_octets_r, earlier_octets_nxt;
  logic                 parse_failed_r,   parse_failed_nxt;

  // result register
  logic       out_valid_r;
  logic       out_addr_valid_r, out_addr_valid_nxt;
  ipv4_addr_t out_address_r,    out_address_nxt;
  logic       out_reserved_r,   out_reserved_nxt;

  logic        in_accept;
  logic        is_digit;
  logic [3:0]  digit_val;
  logic [11:0] octet_acc;
  logic        addr_ok;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  // digit decode and octet accumulate
  assign is_digit  = (in_char_code >= CHAR_ZERO) && (in_char_code <= CHAR_NINE);
  assign digit_val = 4'(in_char_code - CHAR_ZERO);
  assign octet_acc = 12'(octet_value_r) * 12'(DEC_RADIX) + 12'(digit_val);

  // next parse state for one character
  always_comb begin
    octet_value_nxt    = octet_value_r;
    octet_count_nxt    = octet_count_r;
    digit_seen_nxt     = digit_seen_r;
    earlier_octets_nxt = earlier_octets_r;
    parse_failed_nxt   = parse_failed_r;
    if (!parse_failed_r) begin
      priority if (is_digit) begin
        if (octet_acc > OCTET_MAX) begin
          parse_failed_nxt = 1'b1;
        end else if (!digit_seen_r && (octet_count_r >= OCTETS_FULL)) begin
          parse_failed_nxt = 1'b1;
        end else begin
          octet_value_nxt = octet_acc[OCTET_W-1:0];
          if (!digit_seen_r) begin
            octet_count_nxt = octet_count_r + COUNT_W'(1);
            digit_seen_nxt  = 1'b1;
          end
        end
      end else if ((in_char_code == CHAR_DOT) && digit_seen_r) begin
        if (octet_count_r >= OCTETS_FULL) begin
          parse_failed_nxt = 1'b1;
        end else begin
          earlier_octets_nxt = {earlier_octets_r[2*OCTET_W-1:0], octet_value_r};
          octet_value_nxt    = '0;
          digit_seen_nxt     = 1'b0;
        end
      end else begin
        parse_failed_nxt = 1'b1;
      end
    end
  end

  // result for a final character
  assign addr_ok            = !parse_failed_nxt && (octet_count_nxt == OCTETS_FULL);
  assign out_addr_valid_nxt = addr_ok;
  assign out_address_nxt    = addr_ok ? {earlier_octets_nxt, octet_value_nxt} : '0;
  assign out_reserved_nxt   = addr_ok && is_reserved({earlier_octets_nxt, octet_value_nxt});

  // parse state registers, cleared after each final character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octet_value_r    <= '0;
      octet_count_r    <= '0;
      digit_seen_r     <= 1'b0;
      earlier_octets_r <= '0;
      parse_failed_r   <= 1'b0;
    end else if (in_accept) begin
      if (in_final_char) begin
        octet_value_r    <= '0;
        octet_count_r    <= '0;
        digit_seen_r     <= 1'b0;
        earlier_octets_r <= '0;
        parse_failed_r   <= 1'b0;
      end else begin
        octet_value_r    <= octet_value_nxt;
        octet_count_r    <= octet_count_nxt;
        digit_seen_r     <= digit_seen_nxt;
        earlier_octets_r <= earlier_octets_nxt;
        parse_failed_r   <= parse_failed_nxt;
      end
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_final_char) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_accept && in_final_char) begin
      out_addr_valid_r <= out_addr_valid_nxt;
      out_address_r    <= out_address_nxt;
      out_reserved_r   <= out_reserved_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_addr_valid = out_addr_valid_r;
  assign out_address    = out_address_r;
  assign out_reserved   = out_reserved_r;

endmodule

>>> hw/rtl/ipv4tpc_checker.sv
// ----------------------------------------------------------------------------
// ipv4tpc_checker
// Port-level checks on the parser's input and result channels, bound to the top level.
// ----------------------------------------------------------------------------
module ipv4tpc_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_final_char,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_addr_valid,
  input ipv4tpc_pkg::ipv4_addr_t out_address,
  input logic                    out_reserved
);
  import ipv4tpc_pkg::*;

  // reset empties the result register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // an invalid text reports zero address and no reserved flag
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_addr_valid) |-> ((out_address == '0) && !out_reserved))
    else $error("invalid result carries address or reserved flag");

  // a final character always yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_final_char) |=> out_valid)
    else $error("final character produced no result");

  // a non-final character never creates a result
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_final_char && (!out_valid || out_ready))
      |=> !out_valid)
    else $error("result without final character");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_address)
      && $stable(out_addr_valid) && $stable(out_reserved)))
    else $error("stalled result changed");

endmodule

bind ipv4_text_parse_classify_top ipv4tpc_checker u_ipv4tpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_final_char  (in_final_char),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_addr_valid (out_addr_valid),
  .out_address    (out_address),
  .out_reserved   (out_reserved)
);
